FILE: rtl/core/ctp_pkg.sv
// ctp_pkg: shared types, sizes and constants of the colour text parser
// no dependencies

package ctp_pkg;

    localparam int FRAC_DIGITS = 4;
    localparam int ACC_BITS    = 32;
    localparam int ACC_XW      = ACC_BITS + 4;
    localparam int CHAR_W      = 8;
    localparam int CHAN_W      = 8;
    localparam int COLOUR_W    = 4 * CHAN_W;
    localparam int DCNT_W      = 4;

    localparam longint unsigned ALPHA_DEN = 64'(10 ** FRAC_DIGITS);
    localparam int FRAC_W  = $clog2(ALPHA_DEN);
    localparam int FCNT_W  = $clog2(FRAC_DIGITS + 1);

    // alpha = floor(frac * 255 / ALPHA_DEN), exact via reciprocal
    localparam int ALPHA_SH = $clog2(64'd255 * ALPHA_DEN * ALPHA_DEN);
    localparam longint unsigned ALPHA_M =
        ((64'd1 << ALPHA_SH) + ALPHA_DEN - 64'd1) / ALPHA_DEN;
    localparam longint unsigned ALPHA_K = 64'd255 * ALPHA_M;
    localparam int ALPHA_PW = ALPHA_SH + CHAN_W;

    typedef enum logic [13:0] {
        ST_BEFORE     = 14'b00000000000001,
        ST_INT        = 14'b00000000000010,
        ST_HEX        = 14'b00000000000100,
        ST_R          = 14'b00000000001000,
        ST_G          = 14'b00000000010000,
        ST_B          = 14'b00000000100000,
        ST_A          = 14'b00000001000000,
        ST_RED        = 14'b00000010000000,
        ST_GREEN      = 14'b00000100000000,
        ST_BLUE       = 14'b00001000000000,
        ST_ALPHA      = 14'b00010000000000,
        ST_ALPHA_TAIL = 14'b00100000000000,
        ST_END        = 14'b01000000000000,
        ST_ERROR      = 14'b10000000000000
    } t_pstate;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_SYNTAX = 2'd1,
        STAT_EARLY  = 2'd2
    } t_status;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              string_end;
    } t_char_word;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        t_status           status;
    } t_result;

    // weight of fraction digit idx, so the fraction is always scaled to FRAC_DIGITS places
    function automatic logic [FRAC_W-1:0] frac_weight(input logic [FCNT_W-1:0] idx);
        longint unsigned w;
        w = 64'd1;
        for (int i = 0; i < FRAC_DIGITS; i++) begin
            if (FCNT_W'(i) > idx) begin
                w = w * 64'd10;
            end
        end
        return FRAC_W'(w);
    endfunction

endpackage

FILE: rtl/core/ctp_char_if.sv
// ctp_char_if: input channel of the colour text parser, one character per word
// depends on ctp_pkg

interface ctp_char_if;
    logic                       valid;
    logic                       ready;
    logic [ctp_pkg::CHAR_W-1:0] char_code;
    logic                       string_end;

    modport source (output valid, output char_code, output string_end, input ready);
    modport sink   (input valid, input char_code, input string_end, output ready);
endinterface

FILE: rtl/core/ctp_colour_if.sv
// ctp_colour_if: result channel of the colour text parser, one colour per word
// depends on ctp_pkg

interface ctp_colour_if;
    logic                       valid;
    logic                       ready;
    logic [ctp_pkg::CHAN_W-1:0] red;
    logic [ctp_pkg::CHAN_W-1:0] green;
    logic [ctp_pkg::CHAN_W-1:0] blue;
    logic [ctp_pkg::CHAN_W-1:0] alpha;
    logic [1:0]                 status;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output status, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input status, output ready);
endinterface

FILE: rtl/core/ctp_in_stage.sv
// ctp_in_stage: input register of the colour text parser
// depends on ctp_pkg and ctp_char_if

module ctp_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ctp_char_if.sink            i_char,
    input  logic                i_pop,
    output logic                o_valid,
    output ctp_pkg::t_char_word o_word
);

    logic                r_valid;
    ctp_pkg::t_char_word r_word;
    logic                w_take;

    assign i_char.ready = !r_valid || i_pop;
    assign w_take       = i_char.valid && i_char.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_word.char_code  <= i_char.char_code;
            r_word.string_end <= i_char.string_end;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

FILE: rtl/core/ctp_alpha_scale.sv
// ctp_alpha_scale: scales the alpha fraction to 0..255 by a reciprocal multiply
// depends on ctp_pkg

module ctp_alpha_scale (
    input  logic [ctp_pkg::FRAC_W-1:0] i_frac,
    output logic [ctp_pkg::CHAN_W-1:0] o_alpha
);

    localparam logic [ctp_pkg::ALPHA_PW-1:0] K = ctp_pkg::ALPHA_PW'(ctp_pkg::ALPHA_K);

    logic [ctp_pkg::ALPHA_PW-1:0] w_prod;

    assign w_prod  = ctp_pkg::ALPHA_PW'(i_frac) * K;
    assign o_alpha = w_prod[ctp_pkg::ALPHA_SH +: ctp_pkg::CHAN_W];

endmodule

FILE: rtl/core/ctp_parser.sv
// ctp_parser: parse state, accumulators and colour register, one character per cycle while i_take is high
// depends on ctp_pkg and ctp_alpha_scale

module ctp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  ctp_pkg::t_char_word i_word,
    output ctp_pkg::t_result    o_res
);

    localparam logic [ctp_pkg::CHAR_W-1:0] CH_0      = 8'h30;
    localparam logic [ctp_pkg::CHAR_W-1:0] CH_9      = 8'h39;
    localparam logic [ctp_pkg::CHAR_W-1:0] CH_LA     = 8'h61;
    localparam logic [ctp_pkg::CHAR_W-1:0] CH_LB     = 8'h62;
    localparam logic [ctp_pkg::CHAR_W-1:0] CH_LF     = 8'h66;
    localparam logic [ctp_pkg::CHAR_W-1:0] CH_LG     = 8'h67;
    localparam logic [ctp_pkg::CHAR_W-1:0] CH_LR     = 8'h72;
    localparam logic [ctp_pkg::CHAR_W-1:0] CH_LX     = 8'h78;
    localparam logic [ctp_pkg::CHAR_W-1:0] CH_OPEN   = 8'h28;
    localparam logic [ctp_pkg::CHAR_W-1:0] CH_CLOSE  = 8'h29;
    localparam logic [ctp_pkg::CHAR_W-1:0] CH_COMMA  = 8'h2c;
    localparam logic [ctp_pkg::CHAR_W-1:0] CH_DOT    = 8'h2e;
    localparam logic [ctp_pkg::CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [ctp_pkg::CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [ctp_pkg::CHAR_W-1:0] CH_CR     = 8'h0d;
    localparam logic [ctp_pkg::CHAN_W-1:0] CHAN_FULL = 8'hff;

    ctp_pkg::t_pstate                r_state, n_state;
    logic [ctp_pkg::ACC_BITS-1:0]    r_acc, n_acc;
    logic [ctp_pkg::DCNT_W-1:0]      r_dcnt, n_dcnt;
    logic [ctp_pkg::FRAC_W-1:0]      r_frac, n_frac;
    logic [ctp_pkg::FCNT_W-1:0]      r_fcnt, n_fcnt;
    logic                            r_dot, n_dot;
    logic [ctp_pkg::COLOUR_W-1:0]    r_colour, n_colour;

    logic [ctp_pkg::CHAR_W-1:0]      w_c, w_low;
    logic                            w_dig, w_sp, w_hexl;
    logic [3:0]                      w_dval, w_hval;
    logic [ctp_pkg::DCNT_W-1:0]      w_dcnt_inc;
    logic [ctp_pkg::CHAN_W-1:0]      w_frac_alpha, w_fin_alpha;
    logic [ctp_pkg::COLOUR_W-1:0]    w_acc32;
    ctp_pkg::t_status                w_status;

    function automatic logic [ctp_pkg::ACC_BITS-1:0] acc_push(
        input logic [ctp_pkg::ACC_BITS-1:0] acc,
        input logic                         hex,
        input logic [3:0]                   dig
    );
        logic [ctp_pkg::ACC_XW-1:0] v;
        v = hex ? {acc, 4'b0000} : ({3'b000, acc, 1'b0} + {1'b0, acc, 3'b000});
        v = v + ctp_pkg::ACC_XW'(dig);
        return (|v[ctp_pkg::ACC_XW-1:ctp_pkg::ACC_BITS]) ? '1 : v[ctp_pkg::ACC_BITS-1:0];
    endfunction

    ctp_alpha_scale u_alpha (
        .i_frac  (r_frac),
        .o_alpha (w_frac_alpha)
    );

    assign w_c        = i_word.char_code;
    assign w_low      = w_c | 8'h20;
    assign w_dig      = (w_c >= CH_0) && (w_c <= CH_9);
    assign w_sp       = (w_c == CH_SPACE) || ((w_c >= CH_TAB) && (w_c <= CH_CR));
    assign w_hexl     = (w_low >= CH_LA) && (w_low <= CH_LF);
    assign w_dval     = w_c[3:0];
    assign w_hval     = w_low[3:0] + 4'd9;
    assign w_dcnt_inc = (&r_dcnt) ? r_dcnt : r_dcnt + 1'b1;
    assign w_fin_alpha = (r_acc != '0) ? CHAN_FULL : w_frac_alpha;

    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_dcnt   = r_dcnt;
        n_frac   = r_frac;
        n_fcnt   = r_fcnt;
        n_dot    = r_dot;
        n_colour = r_colour;
        w_status = ctp_pkg::STAT_EARLY;
        w_acc32  = '0;

        unique case (r_state)
            ctp_pkg::ST_BEFORE: begin
                if (w_low == CH_LR) begin
                    n_state = ctp_pkg::ST_R;
                end else if (w_dig) begin
                    n_acc   = acc_push(r_acc, 1'b0, w_dval);
                    n_dcnt  = w_dcnt_inc;
                    n_state = ctp_pkg::ST_INT;
                end
            end
            ctp_pkg::ST_R: begin
                n_state = (w_low == CH_LG) ? ctp_pkg::ST_G : ctp_pkg::ST_ERROR;
            end
            ctp_pkg::ST_G: begin
                n_state = (w_low == CH_LB) ? ctp_pkg::ST_B : ctp_pkg::ST_ERROR;
            end
            ctp_pkg::ST_B: begin
                n_state = (w_low == CH_LA) ? ctp_pkg::ST_A : ctp_pkg::ST_ERROR;
            end
            ctp_pkg::ST_A: begin
                if (w_c == CH_OPEN) begin
                    n_state = ctp_pkg::ST_RED;
                end else if (!w_sp) begin
                    n_state = ctp_pkg::ST_ERROR;
                end
            end
            ctp_pkg::ST_RED, ctp_pkg::ST_GREEN, ctp_pkg::ST_BLUE: begin
                if (w_dig) begin
                    n_acc  = acc_push(r_acc, 1'b0, w_dval);
                    n_dcnt = w_dcnt_inc;
                end else if (w_c == CH_COMMA
                             || (w_c == CH_CLOSE && r_state == ctp_pkg::ST_BLUE)) begin
                    n_acc  = '0;
                    n_dcnt = '0;
                    if (r_state == ctp_pkg::ST_RED) begin
                        n_colour[23:16] = r_acc[7:0];
                        n_state         = ctp_pkg::ST_GREEN;
                    end else if (r_state == ctp_pkg::ST_GREEN) begin
                        n_colour[15:8] = r_acc[7:0];
                        n_state        = ctp_pkg::ST_BLUE;
                    end else begin
                        n_colour[7:0] = r_acc[7:0];
                        n_state = (w_c == CH_COMMA) ? ctp_pkg::ST_ALPHA : ctp_pkg::ST_END;
                    end
                end else if (!w_sp) begin
                    n_state = ctp_pkg::ST_ERROR;
                end
            end
            ctp_pkg::ST_ALPHA: begin
                if (w_dig) begin
                    if (!r_dot) begin
                        n_acc  = acc_push(r_acc, 1'b0, w_dval);
                        n_dcnt = w_dcnt_inc;
                    end else if (r_fcnt < ctp_pkg::FCNT_W'(ctp_pkg::FRAC_DIGITS)) begin
                        n_frac = r_frac + ctp_pkg::FRAC_W'(w_dval
                                 * ctp_pkg::frac_weight(r_fcnt));
                        n_fcnt = r_fcnt + 1'b1;
                    end
                end else if (w_c == CH_DOT) begin
                    if (!r_dot) begin
                        n_dot = 1'b1;
                    end else begin
                        n_state = ctp_pkg::ST_ALPHA_TAIL;
                    end
                end else if (w_c == CH_CLOSE || w_sp) begin
                    n_colour[31:24] = w_fin_alpha;
                    n_state         = ctp_pkg::ST_END;
                end
            end
            ctp_pkg::ST_ALPHA_TAIL: begin
                if (w_c == CH_CLOSE || w_sp) begin
                    n_colour[31:24] = w_fin_alpha;
                    n_state         = ctp_pkg::ST_END;
                end
            end
            ctp_pkg::ST_INT: begin
                if (w_dig) begin
                    n_acc  = acc_push(r_acc, 1'b0, w_dval);
                    n_dcnt = w_dcnt_inc;
                end else if (w_low == CH_LX) begin
                    if (r_dcnt == ctp_pkg::DCNT_W'(1) && r_acc == '0) begin
                        n_acc   = '0;
                        n_dcnt  = '0;
                        n_state = ctp_pkg::ST_HEX;
                    end else begin
                        n_state = ctp_pkg::ST_ERROR;
                    end
                end
            end
            ctp_pkg::ST_HEX: begin
                if (w_dig) begin
                    n_acc  = acc_push(r_acc, 1'b1, w_dval);
                    n_dcnt = w_dcnt_inc;
                end else if (w_hexl) begin
                    n_acc  = acc_push(r_acc, 1'b1, w_hval);
                    n_dcnt = w_dcnt_inc;
                end
            end
            ctp_pkg::ST_END, ctp_pkg::ST_ERROR: begin
            end
            default: begin
                n_state = ctp_pkg::ST_ERROR;
            end
        endcase

        // string end: integer forms load the colour, then the parse restarts
        if (i_word.string_end) begin
            w_acc32 = ctp_pkg::COLOUR_W'(n_acc);
            priority case (n_state)
                ctp_pkg::ST_INT: begin
                    n_colour = {CHAN_FULL, w_acc32[7:0], w_acc32[15:8], w_acc32[23:16]};
                    w_status = ctp_pkg::STAT_OK;
                end
                ctp_pkg::ST_HEX: begin
                    n_colour = {CHAN_FULL, w_acc32[23:0]};
                    w_status = ctp_pkg::STAT_OK;
                end
                ctp_pkg::ST_END:   w_status = ctp_pkg::STAT_OK;
                ctp_pkg::ST_ERROR: w_status = ctp_pkg::STAT_SYNTAX;
                default:           w_status = ctp_pkg::STAT_EARLY;
            endcase
            n_state = ctp_pkg::ST_BEFORE;
            n_acc   = '0;
            n_dcnt  = '0;
            n_frac  = '0;
            n_fcnt  = '0;
            n_dot   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ctp_pkg::ST_BEFORE;
            r_acc    <= '0;
            r_dcnt   <= '0;
            r_frac   <= '0;
            r_fcnt   <= '0;
            r_dot    <= 1'b0;
            r_colour <= '0;
        end else if (i_take) begin
            r_state  <= n_state;
            r_acc    <= n_acc;
            r_dcnt   <= n_dcnt;
            r_frac   <= n_frac;
            r_fcnt   <= n_fcnt;
            r_dot    <= n_dot;
            r_colour <= n_colour;
        end
    end

    assign o_res.red    = n_colour[23:16];
    assign o_res.green  = n_colour[15:8];
    assign o_res.blue   = n_colour[7:0];
    assign o_res.alpha  = n_colour[31:24];
    assign o_res.status = w_status;

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_word.string_end |=> r_state == ctp_pkg::ST_BEFORE && r_acc == '0
            && r_fcnt == '0 && !r_dot)
        else $error("parse state not cleared after string end");

    a_colour_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_take |=> $stable(r_colour))
        else $error("colour register changed without a character");

    a_frac_dot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_dot |-> r_fcnt == '0 && r_frac == '0)
        else $error("fraction digits taken before the dot");

endmodule

FILE: rtl/core/ctp_out_stage.sv
// ctp_out_stage: result register of the colour text parser
// depends on ctp_pkg and ctp_colour_if

module ctp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ctp_pkg::t_result i_res,
    output logic             o_space,
    ctp_colour_if.source     o_colour
);

    logic             r_valid;
    ctp_pkg::t_result r_res;

    assign o_space = !r_valid || o_colour.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_colour.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_colour.valid  = r_valid;
    assign o_colour.red    = r_res.red;
    assign o_colour.green  = r_res.green;
    assign o_colour.blue   = r_res.blue;
    assign o_colour.alpha  = r_res.alpha;
    assign o_colour.status = r_res.status;

endmodule

FILE: rtl/core/colour_text_parser_core.sv
// colour_text_parser_core: top level of the colour text parser
// depends on ctp_pkg, ctp_char_if, ctp_colour_if, ctp_in_stage, ctp_parser, ctp_out_stage
//
//   port       dir   word
//   i_char     in    char_code[7:0], string_end
//   o_colour   out   red, green, blue, alpha [7:0], status[1:0]
//
// one character per cycle unless a held result stalls a string end; a result word leaves
// after its last character is taken, passing the input register and the result register around the parser
// synchronous active-low reset clears the parse state and the colour to zero
// a held result stalls only the string end character; others keep flowing

module colour_text_parser_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ctp_char_if.sink     i_char,
    ctp_colour_if.source o_colour
);

    logic                w_in_valid;
    ctp_pkg::t_char_word w_word;
    logic                w_space;
    logic                w_pop;
    logic                w_load;
    ctp_pkg::t_result    w_res;

    assign w_pop  = w_in_valid && (!w_word.string_end || w_space);
    assign w_load = w_pop && w_word.string_end;

    ctp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_pop   (w_pop),
        .o_valid (w_in_valid),
        .o_word  (w_word)
    );

    ctp_parser u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_pop),
        .i_word  (w_word),
        .o_res   (w_res)
    );

    ctp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_res    (w_res),
        .o_space  (w_space),
        .o_colour (o_colour)
    );

endmodule
